@@ rtl/bol_pkg.sv @@
// Shared types, codes and widths for the bounded ordered array list.
// Used by bol_cell and by the top level bounded_ordered_array_list.
package bol_pkg;

   // Fixed field widths of the stream and configuration ports.
   localparam int KIND_WIDTH      = 3;
   localparam int POSITION_WIDTH  = 6;
   localparam int VALUE_WIDTH     = 32;
   localparam int STATUS_WIDTH    = 2;
   localparam int COUNT_OUT_WIDTH = 7;
   localparam int LIMIT_WIDTH     = 7;
   localparam int REQ_DATA_WIDTH  = 48;
   localparam int RSP_DATA_WIDTH  = 48;
   localparam int CSR_INDEX_WIDTH = 1;
   localparam int CSR_DATA_WIDTH  = 7;

   // Parameter defaults.
   localparam int DEPTH_DEFAULT       = 64;
   localparam int ENTRY_WIDTH_DEFAULT = 32;

   // Register reset values.
   localparam logic [LIMIT_WIDTH-1:0] CAPACITY_LIMIT_RESET = LIMIT_WIDTH'(64);

   // Configuration register indexes.
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_CAPACITY_LIMIT = 1'b0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_COMPARE_MODE   = 1'b1;

   typedef enum logic [KIND_WIDTH-1:0] {
      KIND_INSERT = 3'd0,
      KIND_SORTED = 3'd1,
      KIND_APPEND = 3'd2,
      KIND_REMOVE = 3'd3,
      KIND_TAKE   = 3'd4
   } kind_type;

   typedef enum logic [STATUS_WIDTH-1:0] {
      ST_OK    = 2'd0,
      ST_FULL  = 2'd1,
      ST_INDEX = 2'd2,
      ST_NONE  = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      CELL_HOLD       = 2'd0,
      CELL_SHIFT_UP   = 2'd1,
      CELL_SHIFT_DOWN = 2'd2
   } cell_op_type;

   // Command broadcast from the controller to every cell.
   typedef struct packed {
      logic        capture;  // register the compare flag this cycle
      logic        signed_cmp;
      cell_op_type op;
   } cell_cmd_type;

endpackage

@@ rtl/bol_cell.sv @@
// One storage cell of the list: holds a single entry and its compare flag.
// Depends on bol_pkg for the command struct and cell operation codes.
module bol_cell
   import bol_pkg::*;
#(
   parameter int ENTRY_WIDTH = ENTRY_WIDTH_DEFAULT,
   parameter int COUNT_WIDTH = 7,
   parameter int INDEX       = 0
) (
   input  logic                   clock,
   input  logic                   reset,
   input  cell_cmd_type           cmd,
   input  logic [ENTRY_WIDTH-1:0] value,
   input  logic [COUNT_WIDTH-1:0] count,
   input  logic [COUNT_WIDTH-1:0] bound,
   input  logic [ENTRY_WIDTH-1:0] left_entry,
   input  logic [ENTRY_WIDTH-1:0] right_entry,
   output logic [ENTRY_WIDTH-1:0] entry_out,
   output logic                   below_out
);

   localparam logic [COUNT_WIDTH-1:0] MY_INDEX  = COUNT_WIDTH'(INDEX);
   localparam logic [ENTRY_WIDTH-1:0] SIGN_MASK = ENTRY_WIDTH'(1) << (ENTRY_WIDTH - 1);

   logic [ENTRY_WIDTH-1:0] entry_ff, entry_in;
   logic                   below_ff, below_in;
   logic [ENTRY_WIDTH-1:0] cmp_a, cmp_b;

   // The incoming value orders below this entry; only live entries count.
   always_comb begin
      cmp_a = cmd.signed_cmp ? (value ^ SIGN_MASK) : value;
      cmp_b = cmd.signed_cmp ? (entry_ff ^ SIGN_MASK) : entry_ff;
      below_in = below_ff;
      if (cmd.capture) begin
         below_in = (MY_INDEX < count) && (cmp_a < cmp_b);
      end
   end

   always_comb begin
      entry_in = entry_ff;
      case (cmd.op)
         CELL_SHIFT_UP: begin
            if (MY_INDEX > bound) begin
               entry_in = left_entry;
            end else if (MY_INDEX == bound) begin
               entry_in = value;
            end
         end
         CELL_SHIFT_DOWN: begin
            if (MY_INDEX >= bound) begin
               entry_in = right_entry;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         entry_ff <= '0;
         below_ff <= 1'b0;
      end else begin
         entry_ff <= entry_in;
         below_ff <= below_in;
      end
   end

   assign entry_out = entry_ff;
   assign below_out = below_ff;

endmodule

@@ rtl/bounded_ordered_array_list.sv @@
// Top level of the bounded ordered array list: controller, result register
// and the row of bol_cell storage cells. Depends on bol_pkg and bol_cell.
//
// The list is a row of DEPTH cells, one entry each, that move data to their
// neighbors. In the cycle a request word is accepted, every cell compares
// the new value against its own entry in parallel; then, once the result
// register is free, the controller picks the first cell that orders above
// the value (for sorted insert), checks capacity and index, and all cells
// shift up, shift down or hold at once. The result word is then held in an
// output register, and the block takes the next request while that result
// waits. If a result is still not taken when the next operation is ready to
// commit, the commit waits for the result register to free up. Entries at
// and beyond the count always read as zero, and the whole store is cleared
// by reset. Configuration writes take effect immediately and should be made
// only while the block is idle.
module bounded_ordered_array_list
   import bol_pkg::*;
#(
   parameter int DEPTH       = DEPTH_DEFAULT,
   parameter int ENTRY_WIDTH = ENTRY_WIDTH_DEFAULT
) (
   input  logic                       clock,
   input  logic                       reset,
   // Request stream. tdata from bit 0: kind[2:0], position[5:0],
   // entry_value[31:0], zero fill.
   input  logic                       req_tvalid,
   output logic                       req_tready,
   input  logic [REQ_DATA_WIDTH-1:0]  req_tdata,
   // Response stream. tdata from bit 0: taken_value[31:0], status[1:0],
   // entry_count[6:0], is_empty, zero fill.
   output logic                       rsp_tvalid,
   input  logic                       rsp_tready,
   output logic [RSP_DATA_WIDTH-1:0]  rsp_tdata,
   // Configuration write port.
   input  logic                       csr_wen,
   input  logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [CSR_DATA_WIDTH-1:0]  csr_wdata
);

   localparam int COUNT_WIDTH = $clog2(DEPTH + 1);
   localparam int FULL_WIDTH  = (COUNT_WIDTH + 1 > LIMIT_WIDTH) ? COUNT_WIDTH + 1 : LIMIT_WIDTH;
   localparam int POS_WIDTH   = (COUNT_WIDTH > POSITION_WIDTH) ? COUNT_WIDTH : POSITION_WIDTH;
   localparam int RSP_FILL_WIDTH = RSP_DATA_WIDTH - VALUE_WIDTH - STATUS_WIDTH
                                   - COUNT_OUT_WIDTH - 1;

   typedef enum logic {
      S_IDLE,
      S_EXEC
   } state_type;

   // Controller state and configuration.
   state_type                     state_ff, state_in;
   logic [COUNT_WIDTH-1:0]        count_ff, count_in;
   logic [LIMIT_WIDTH-1:0]        limit_ff, limit_in;
   logic                          mode_ff, mode_in;

   // The request word being worked on.
   kind_type                      kind_ff, kind_in;
   logic [POSITION_WIDTH-1:0]     pos_ff, pos_in;
   logic [ENTRY_WIDTH-1:0]        val_ff, val_in;

   // Result register.
   logic                          rsp_valid_ff, rsp_valid_in;
   logic [VALUE_WIDTH-1:0]        rsp_taken_ff, rsp_taken_in;
   status_type                    rsp_status_ff, rsp_status_in;
   logic [COUNT_OUT_WIDTH-1:0]    rsp_count_ff, rsp_count_in;
   logic                          rsp_empty_ff, rsp_empty_in;

   // Cell row.
   cell_cmd_type                  cell_cmd;
   logic [ENTRY_WIDTH-1:0]        cell_value;
   logic [COUNT_WIDTH-1:0]        cell_bound;
   logic [ENTRY_WIDTH-1:0]        cell_entry [DEPTH];
   logic [DEPTH-1:0]              cell_below;

   // Decision for the operation held in the request registers.
   logic                          req_fire;
   logic                          exec_go;
   logic                          list_full;
   logic [POS_WIDTH-1:0]          pos_wide, count_wide;
   logic [COUNT_WIDTH-1:0]        sorted_index;
   status_type                    op_status;
   cell_op_type                   op_cell;
   logic [COUNT_WIDTH-1:0]        op_bound;
   logic [COUNT_WIDTH-1:0]        op_count;
   logic [VALUE_WIDTH-1:0]        op_taken;

   assign req_fire = req_tvalid && req_tready;
   assign req_tready = (state_ff == S_IDLE);
   assign exec_go = (state_ff == S_EXEC) && (!rsp_valid_ff || rsp_tready);

   // An insert needs count + 1 below the limit and a free cell.
   assign list_full = ((FULL_WIDTH'(count_ff) + FULL_WIDTH'(1)) >= FULL_WIDTH'(limit_ff))
                      || (count_ff >= COUNT_WIDTH'(DEPTH));
   assign pos_wide   = POS_WIDTH'(pos_ff);
   assign count_wide = POS_WIDTH'(count_ff);

   // First live cell whose entry orders above the new value; the count if
   // there is none. Only live cells raise their compare flag.
   always_comb begin
      sorted_index = count_ff;
      for (int i = DEPTH - 1; i >= 0; i--) begin
         if (cell_below[i]) begin
            sorted_index = COUNT_WIDTH'(i);
         end
      end
   end

   always_comb begin
      op_status = ST_OK;
      op_cell   = CELL_HOLD;
      op_bound  = count_ff;
      op_count  = count_ff;
      op_taken  = '0;
      unique case (kind_ff)
         KIND_INSERT: begin
            if (list_full) begin
               op_status = ST_FULL;
            end else if (pos_wide > count_wide) begin
               op_status = ST_INDEX;
            end else begin
               op_cell  = CELL_SHIFT_UP;
               op_bound = COUNT_WIDTH'(pos_ff);
            end
         end
         KIND_SORTED: begin
            if (list_full) begin
               op_status = ST_FULL;
            end else begin
               op_cell  = CELL_SHIFT_UP;
               op_bound = sorted_index;
            end
         end
         KIND_APPEND: begin
            if (list_full) begin
               op_status = ST_FULL;
            end else begin
               op_cell = CELL_SHIFT_UP;
            end
         end
         KIND_REMOVE: begin
            if (pos_wide >= count_wide) begin
               op_status = ST_NONE;
            end else begin
               op_cell  = CELL_SHIFT_DOWN;
               op_bound = COUNT_WIDTH'(pos_ff);
            end
         end
         KIND_TAKE: begin
            // On an empty list the head cell holds zero.
            op_taken = VALUE_WIDTH'(cell_entry[0]);
            if (count_ff == '0) begin
               op_status = ST_NONE;
            end else begin
               op_cell  = CELL_SHIFT_DOWN;
               op_bound = '0;
            end
         end
         default: begin
         end
      endcase
      if (op_cell == CELL_SHIFT_UP) begin
         op_count = count_ff + COUNT_WIDTH'(1);
      end else if (op_cell == CELL_SHIFT_DOWN) begin
         op_count = count_ff - COUNT_WIDTH'(1);
      end
   end

   // Cells compare against the arriving value, then load the held one.
   always_comb begin
      cell_cmd.capture    = req_fire;
      cell_cmd.signed_cmp = mode_ff;
      cell_cmd.op         = exec_go ? op_cell : CELL_HOLD;
      cell_value = (state_ff == S_IDLE)
                   ? ENTRY_WIDTH'(req_tdata[KIND_WIDTH+POSITION_WIDTH +: VALUE_WIDTH])
                   : val_ff;
      cell_bound = op_bound;
   end

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      limit_in      = limit_ff;
      mode_in       = mode_ff;
      kind_in       = kind_ff;
      pos_in        = pos_ff;
      val_in        = val_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_taken_in  = rsp_taken_ff;
      rsp_status_in = rsp_status_ff;
      rsp_count_in  = rsp_count_ff;
      rsp_empty_in  = rsp_empty_ff;

      if (csr_wen) begin
         unique case (csr_index)
            CSR_CAPACITY_LIMIT: limit_in = csr_wdata;
            CSR_COMPARE_MODE:   mode_in  = csr_wdata[0];
            default: begin
            end
         endcase
      end

      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               kind_in  = kind_type'(req_tdata[KIND_WIDTH-1:0]);
               pos_in   = req_tdata[KIND_WIDTH +: POSITION_WIDTH];
               val_in   = ENTRY_WIDTH'(req_tdata[KIND_WIDTH+POSITION_WIDTH +: VALUE_WIDTH]);
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            if (exec_go) begin
               count_in      = op_count;
               rsp_valid_in  = 1'b1;
               rsp_taken_in  = op_taken;
               rsp_status_in = op_status;
               rsp_count_in  = COUNT_OUT_WIDTH'(op_count);
               rsp_empty_in  = (op_count == '0);
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         limit_ff     <= CAPACITY_LIMIT_RESET;
         mode_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         limit_ff     <= limit_in;
         mode_ff      <= mode_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      kind_ff       <= kind_in;
      pos_ff        <= pos_in;
      val_ff        <= val_in;
      rsp_taken_ff  <= rsp_taken_in;
      rsp_status_ff <= rsp_status_in;
      rsp_count_ff  <= rsp_count_in;
      rsp_empty_ff  <= rsp_empty_in;
   end

   for (genvar g = 0; g < DEPTH; g++) begin : g_cell
      logic [ENTRY_WIDTH-1:0] left_entry, right_entry;
      if (g == 0) begin : g_head
         assign left_entry = '0;
      end else begin : g_mid
         assign left_entry = cell_entry[g-1];
      end
      if (g == DEPTH - 1) begin : g_tail
         assign right_entry = '0;
      end else begin : g_body
         assign right_entry = cell_entry[g+1];
      end
      bol_cell #(
         .ENTRY_WIDTH (ENTRY_WIDTH),
         .COUNT_WIDTH (COUNT_WIDTH),
         .INDEX       (g)
      ) u_cell (
         .clock       (clock),
         .reset       (reset),
         .cmd         (cell_cmd),
         .value       (cell_value),
         .count       (count_ff),
         .bound       (cell_bound),
         .left_entry  (left_entry),
         .right_entry (right_entry),
         .entry_out   (cell_entry[g]),
         .below_out   (cell_below[g])
      );
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{RSP_FILL_WIDTH{1'b0}},
                        rsp_empty_ff, rsp_count_ff, rsp_status_ff, rsp_taken_ff};

   // The count never exceeds the number of cells.
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= COUNT_WIDTH'(DEPTH))
      else $error("entry count beyond depth");

   // The count moves only when an operation commits.
   a_count_commit: assert property (@(posedge clock) disable iff (reset)
      (count_ff != $past(count_ff)) |-> $past(exec_go))
      else $error("entry count changed outside a commit");

   // A refused operation leaves the count alone.
   a_refused_hold: assert property (@(posedge clock) disable iff (reset)
      (exec_go && op_status != ST_OK) |=> $stable(count_ff))
      else $error("refused operation changed the count");

   // The top cell holds data only when the list is completely full.
   a_tail_zero: assert property (@(posedge clock) disable iff (reset)
      (cell_entry[DEPTH-1] != '0) |-> (count_ff == COUNT_WIDTH'(DEPTH)))
      else $error("cell beyond the count holds data");

   // An accepted request always moves the controller into execution on the following cycle.
   a_accept_exec: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> (state_ff == S_EXEC))
      else $error("accepted request not taken into execution");

endmodule
